// ===== rtl/pidc_pkg.sv =====
// Shared types, constants and saturation helpers for the PID step block.
// Used by pidc_div and pid_controller_step; depends on nothing else.

package pidc_pkg;

   localparam int DataW   = 32;
   localparam int PeriodW = 31;
   localparam int QFrac   = 16;
   localparam int DivW    = DataW + QFrac;
   localparam int CsrIdxW = 3;

   typedef logic signed [DataW-1:0] q16_type;

   // Item codes carried on the mode field; the spare code falls to a default arm.
   typedef enum logic [1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_TARGET = 2'd1,
      MODE_CLEAR  = 2'd2
   } mode_type;

   // Register indexes of the control port.
   localparam logic [CsrIdxW-1:0] CSR_PROP_GAIN     = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_INTEG_GAIN    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_DERIV_GAIN    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_SAMPLE_PERIOD = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_TARGET_UPPER  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_TARGET_LOWER  = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_LOOP_ENABLE   = 3'd6;

   localparam q16_type Q16_MAX = 32'sh7FFF_FFFF;
   localparam q16_type Q16_MIN = 32'sh8000_0000;
   localparam logic [PeriodW-1:0] PERIOD_RESET = 31'd65536;

   // Integral clamp, +/-10000.0 in Q16.16.
   localparam logic signed [DataW:0] INTEG_LIMIT_POS = 33'sd655360000;
   localparam logic signed [DataW:0] INTEG_LIMIT_NEG = -33'sd655360000;

   typedef struct packed {
      logic                start;
      logic [DivW-1:0]     dividend;
      logic [PeriodW-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DivW-1:0]     quotient;
   } div_rsp_type;

   // Saturate a 33-bit sum or difference to 32 bits.
   function automatic q16_type sat33(input logic signed [DataW:0] v);
      q16_type r;
      if (v[DataW] != v[DataW-1]) begin
         r = v[DataW] ? Q16_MIN : Q16_MAX;
      end else begin
         r = v[DataW-1:0];
      end
      return r;
   endfunction

   // Q16.16 product: floor shift by the fraction width, then saturate.
   function automatic q16_type qsat(input logic signed [2*DataW-1:0] p);
      logic [DataW-QFrac:0] hi;
      q16_type              r;
      hi = p[2*DataW-1:DataW+QFrac-1];
      if (hi == '0 || hi == '1) begin
         r = p[DataW+QFrac-1:QFrac];
      end else begin
         r = p[2*DataW-1] ? Q16_MIN : Q16_MAX;
      end
      return r;
   endfunction

endpackage

// ===== rtl/pidc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the derivative term.
// Depends on pidc_pkg for widths and the request/response structs.

module pidc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pidc_pkg::div_req_type div_req,
   output pidc_pkg::div_rsp_type div_rsp
);

   localparam int CntW = $clog2(pidc_pkg::DivW + 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CntW-1:0]              count_ff, count_in;
   logic [pidc_pkg::DivW-1:0]    quot_ff, quot_in;
   logic [pidc_pkg::PeriodW-1:0] rem_ff, rem_in;
   logic [pidc_pkg::PeriodW-1:0] divisor_ff, divisor_in;

   logic [pidc_pkg::PeriodW:0]   trial;
   logic [pidc_pkg::PeriodW:0]   trial_sub;
   logic                         fits;

   assign trial     = {rem_ff, quot_ff[pidc_pkg::DivW-1]};
   assign trial_sub = trial - {1'b0, divisor_ff};
   assign fits      = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = done_ff;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         done_in    = 1'b0;
         count_in   = CntW'(pidc_pkg::DivW);
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // shift in one quotient bit and keep the partial remainder
         quot_in  = {quot_ff[pidc_pkg::DivW-2:0], fits};
         rem_in   = fits ? trial_sub[pidc_pkg::PeriodW-1:0] : trial[pidc_pkg::PeriodW-1:0];
         count_in = count_ff - CntW'(1);
         if (count_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

// ===== rtl/pid_controller_step.sv =====
// PID controller step in signed Q16.16: top level with control registers and sequencer.
// Depends on pidc_pkg and pidc_div.
//
// Usage:
//  - Control port (csr_*): one word writes one register, indexes 0..6 in the order
//    proportional, integral, derivative gain, sample period, upper and lower target
//    limit, loop enable. Index 7 is dropped. csr_ready is always high; write only
//    while the block is idle.
//  - Request port (req_*): one word per item. An enabled sample forms the error and
//    runs the PID; mode target loads a clamped setpoint; mode clear zeroes the integral.
//  - Response port (rsp_*): exactly one word per request, in order: drive and the
//    last stored error.
//  - An enabled sample runs four multiplies on one shared 32x32 multiplier and a 48-bit
//    restoring divide (one bit per cycle) for the derivative; req_ready stays low until
//    its response is written and comes back with it. A sample with the loop disabled,
//    and every other item, goes straight to the final step and returns the setpoint.
//  - The result sits in an output register; a new word is accepted while it waits.
//    A stalled receiver holds the sequencer in its last step until the register
//    frees up, so nothing is lost.
//  - Synchronous reset loads the register reset values, clears setpoint, integral
//    and stored error, and empties the output register.

module pid_controller_step (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_mode,
   input  logic signed [31:0]               req_value,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [31:0]               rsp_drive,
   output logic signed [31:0]               rsp_last_error,
   // control register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pidc_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [31:0]                      csr_wdata
);

   // one-hot sequencer states
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DIFF  = 9'b000000010,
      S_INTEG = 9'b000000100,
      S_PTERM = 9'b000001000,
      S_ITERM = 9'b000010000,
      S_DIV   = 9'b000100000,
      S_DMUL  = 9'b001000000,
      S_DADD  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   // control registers
   pidc_pkg::q16_type             prop_gain_ff;
   pidc_pkg::q16_type             integ_gain_ff;
   pidc_pkg::q16_type             deriv_gain_ff;
   logic [pidc_pkg::PeriodW-1:0]  period_ff;
   pidc_pkg::q16_type             upper_ff;
   pidc_pkg::q16_type             lower_ff;
   logic                          enable_ff;

   // controller state
   state_type                     state_ff, state_in;
   pidc_pkg::q16_type             setpoint_ff, setpoint_in;
   pidc_pkg::q16_type             integ_ff, integ_in;
   pidc_pkg::q16_type             prev_err_ff, prev_err_in;

   // working registers
   pidc_pkg::q16_type             err_ff, err_in;
   pidc_pkg::q16_type             diff_ff, diff_in;
   pidc_pkg::q16_type             deriv_ff, deriv_in;
   pidc_pkg::q16_type             acc_ff, acc_in;
   logic signed [63:0]            prod_ff, prod_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   pidc_pkg::q16_type             rsp_drive_ff, rsp_drive_in;
   pidc_pkg::q16_type             rsp_err_ff, rsp_err_in;

   pidc_pkg::div_req_type         div_req;
   pidc_pkg::div_rsp_type         div_rsp;

   pidc_pkg::q16_type             mul_a, mul_b;
   pidc_pkg::q16_type             prod_q;
   pidc_pkg::q16_type             deriv_sat;
   pidc_pkg::q16_type             new_target;
   logic [31:0]                   diff_mag;
   logic signed [32:0]            integ_sum;
   logic                          out_free;
   logic                          req_fire;

   assign req_ready = state_ff == S_IDLE;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------- control writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         period_ff     <= pidc_pkg::PERIOD_RESET;
         upper_ff      <= pidc_pkg::Q16_MAX;
         lower_ff      <= pidc_pkg::Q16_MIN;
         enable_ff     <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            pidc_pkg::CSR_PROP_GAIN:     prop_gain_ff  <= csr_wdata;
            pidc_pkg::CSR_INTEG_GAIN:    integ_gain_ff <= csr_wdata;
            pidc_pkg::CSR_DERIV_GAIN:    deriv_gain_ff <= csr_wdata;
            pidc_pkg::CSR_SAMPLE_PERIOD: period_ff     <= csr_wdata[pidc_pkg::PeriodW-1:0];
            pidc_pkg::CSR_TARGET_UPPER:  upper_ff      <= csr_wdata;
            pidc_pkg::CSR_TARGET_LOWER:  lower_ff      <= csr_wdata;
            pidc_pkg::CSR_LOOP_ENABLE:   enable_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- shared multiplier
   // Operands follow the sequencer step; the product is always registered.
   always_comb begin
      case (state_ff)
         S_DIFF:  begin
            mul_a = err_ff;
            mul_b = {1'b0, period_ff};
         end
         S_INTEG: begin
            mul_a = err_ff;
            mul_b = prop_gain_ff;
         end
         S_PTERM: begin
            mul_a = integ_ff;
            mul_b = integ_gain_ff;
         end
         S_DMUL:  begin
            mul_a = deriv_ff;
            mul_b = deriv_gain_ff;
         end
         default: begin
            mul_a = err_ff;
            mul_b = prop_gain_ff;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign prod_q  = pidc_pkg::qsat(prod_ff);

   // ---------------------------------------------------------------- derivative divide
   // Divide the magnitude of diff * 2^16 by dt; a zero dt yields an all-ones quotient,
   // which saturates to the sign of the difference below.
   assign diff_mag         = diff_ff[31] ? (~diff_ff + 32'd1) : diff_ff;
   assign div_req.start    = state_ff == S_INTEG;
   assign div_req.dividend = {diff_mag, {pidc_pkg::QFrac{1'b0}}};
   assign div_req.divisor  = period_ff;

   pidc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      if (diff_ff == '0) begin
         deriv_sat = '0;
      end else if (!diff_ff[31]) begin
         deriv_sat = (div_rsp.quotient[pidc_pkg::DivW-1:31] != '0) ?
                     pidc_pkg::Q16_MAX : div_rsp.quotient[31:0];
      end else begin
         deriv_sat = (div_rsp.quotient > 48'h0000_8000_0000) ?
                     pidc_pkg::Q16_MIN : (~div_rsp.quotient[31:0] + 32'd1);
      end
   end

   // ---------------------------------------------------------------- target clamp
   always_comb begin
      if (req_value > upper_ff) begin
         new_target = upper_ff;
      end else if (req_value < lower_ff) begin
         new_target = lower_ff;
      end else begin
         new_target = req_value;
      end
   end

   assign integ_sum = {integ_ff[31], integ_ff} + {prod_q[31], prod_q};

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      setpoint_in  = setpoint_ff;
      integ_in     = integ_ff;
      prev_err_in  = prev_err_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      deriv_in     = deriv_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_drive_in = rsp_drive_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_DONE;
               acc_in   = setpoint_ff;
               case (pidc_pkg::mode_type'(req_mode))
                  pidc_pkg::MODE_SAMPLE: begin
                     if (enable_ff) begin
                        err_in   = pidc_pkg::sat33({setpoint_ff[31], setpoint_ff}
                                                   - {req_value[31], req_value});
                        state_in = S_DIFF;
                     end
                  end
                  pidc_pkg::MODE_TARGET: begin
                     setpoint_in = new_target;
                     acc_in      = new_target;
                  end
                  pidc_pkg::MODE_CLEAR: begin
                     integ_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_DIFF: begin
            diff_in  = pidc_pkg::sat33({err_ff[31], err_ff} - {prev_err_ff[31], prev_err_ff});
            state_in = S_INTEG;
         end
         S_INTEG: begin
            // integral clamp also covers the 32-bit saturation
            if (integ_sum > pidc_pkg::INTEG_LIMIT_POS) begin
               integ_in = pidc_pkg::INTEG_LIMIT_POS[31:0];
            end else if (integ_sum < pidc_pkg::INTEG_LIMIT_NEG) begin
               integ_in = pidc_pkg::INTEG_LIMIT_NEG[31:0];
            end else begin
               integ_in = integ_sum[31:0];
            end
            prev_err_in = err_ff;
            state_in    = S_PTERM;
         end
         S_PTERM: begin
            acc_in   = prod_q;
            state_in = S_ITERM;
         end
         S_ITERM: begin
            acc_in   = pidc_pkg::sat33({acc_ff[31], acc_ff} + {prod_q[31], prod_q});
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               deriv_in = deriv_sat;
               state_in = S_DMUL;
            end
         end
         S_DMUL: begin
            state_in = S_DADD;
         end
         S_DADD: begin
            acc_in   = pidc_pkg::sat33({acc_ff[31], acc_ff} + {prod_q[31], prod_q});
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register can take the word
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = acc_ff;
               rsp_err_in   = prev_err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         setpoint_ff  <= '0;
         integ_ff     <= '0;
         prev_err_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         setpoint_ff  <= setpoint_in;
         integ_ff     <= integ_in;
         prev_err_ff  <= prev_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff       <= err_in;
      diff_ff      <= diff_in;
      deriv_ff     <= deriv_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive      = rsp_drive_ff;
   assign rsp_last_error = rsp_err_ff;

endmodule
